// File: rtl/bpa_pkg.sv
// Buddy page allocator package: payload structs, codes, frame tags and
// sequencer states. Depends on nothing.
package bpa_pkg;

    localparam int PAGES_DEF     = 1024;
    localparam int MAX_ORDER_DEF = 10;

    localparam int ACTION_W = 2;
    localparam int PIDX_W   = 10;
    localparam int PCNT_W   = 11;
    localparam int BIDX_W   = 10;
    localparam int ORD_W    = 4;
    localparam int USABLE_W = 11;
    localparam int TAG_W    = 6;
    localparam int CFG_IDX_W = 1;

    // Frame tags; a free head carries its order as its tag
    localparam logic [TAG_W-1:0] TAG_ALLOC_BASE = 6'd32;
    localparam logic [TAG_W-1:0] TAG_BUDDY      = 6'd61;
    localparam logic [TAG_W-1:0] TAG_ALLOC_TAIL = 6'd62;
    localparam logic [TAG_W-1:0] TAG_USED       = 6'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE = 1'd1;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_BAD      = 3'd2,
        ST_NOMEM    = 3'd3,
        ST_NOTHEAD  = 3'd4
    } t_status;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PIDX_W-1:0]   page_index;
        logic [PCNT_W-1:0]   req_pages;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [BIDX_W-1:0] block_index;
        logic [ORD_W-1:0]  block_order;
        logic [ORD_W-1:0]  final_order;
    } t_out;

    typedef struct packed {
        logic                enable;
        logic [USABLE_W-1:0] usable_pages;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_SCAN,
        S_CARVE,
        S_ALLOC_POP,
        S_SPLIT,
        S_FREE_TAG,
        S_MERGE,
        S_MERGE_TAG,
        S_UL_RD,
        S_UL_WT,
        S_MARK,
        S_DONE
    } t_state;

endpackage

// File: rtl/bpa_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Depends on nothing.
module bpa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bpa_seq.sv
// Allocator sequencer: frame tag and link memories, list heads, and the
// state machine for add, alloc and free. Depends on bpa_pkg and bpa_ram.
module bpa_seq import bpa_pkg::*; #(
    parameter int PAGES     = PAGES_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_busy,
    input  t_in  i_in,
    input  logic i_res_ready,
    output logic o_res_valid,
    output t_out o_res
);

    localparam int IW  = $clog2(PAGES);
    localparam int LW  = IW + 1;
    localparam int AW1 = (IW + 1 > MAX_ORDER + 1) ? IW + 1 : MAX_ORDER + 1;
    localparam int AW  = ((AW1 > PCNT_W + 1) ? AW1 : PCNT_W + 1) + 1;
    localparam int OW  = $clog2(MAX_ORDER + 2);
    localparam logic [LW-1:0] LINK_NONE = '1;
    localparam logic [AW-1:0] PAGES_A = AW'(PAGES);

    function automatic logic [OW-1:0] f_need(input logic [AW-1:0] cnt);
        logic [OW-1:0] n;
        n = OW'(MAX_ORDER + 1);
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if ((AW'(1) << k) >= cnt) n = OW'(k);
        end
        return n;
    endfunction

    // Largest order that fits the count and keeps the start aligned
    function automatic logic [OW-1:0] f_carve(input logic [AW-1:0] s,
                                              input logic [AW-1:0] cnt);
        logic [OW-1:0] o;
        o = '0;
        for (int k = 1; k <= MAX_ORDER; k++) begin
            if ((AW'(1) << k) <= cnt && (s & ((AW'(1) << k) - AW'(1))) == '0) begin
                o = OW'(k);
            end
        end
        return o;
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    logic [AW-1:0] r_ptr, n_ptr, r_end, n_end, r_s, n_s, r_cnt, n_cnt;
    logic [AW-1:0] r_mk_base, n_mk_base, r_mk_i, n_mk_i, r_mk_n, n_mk_n;
    logic [TAG_W-1:0] r_mk_head, n_mk_head, r_mk_tail, n_mk_tail;
    logic [OW-1:0] r_cur, n_cur, r_need, n_need, r_mo, n_mo, r_order, n_order;
    logic [IW-1:0] r_idx, n_idx, r_mi, n_mi, r_b, n_b;
    logic [LW-1:0] r_prev, n_prev, r_ucur, n_ucur;
    logic [LW-1:0] r_head [MAX_ORDER+1];
    logic [LW-1:0] n_head [MAX_ORDER+1];
    t_out r_res, n_res;

    logic             tag_we, link_we;
    logic [IW-1:0]    tag_waddr, tag_raddr, link_waddr, link_raddr;
    logic [TAG_W-1:0] tag_wdata, w_tag_rd;
    logic [LW-1:0]    link_wdata, w_link_rd;

    logic [AW-1:0]    lim, end_a, addr, half, b;
    logic [OW-1:0]    need, cur, ord;
    logic             found, fin;
    logic             mk_go, mk_push;
    logic [AW-1:0]    mk_base;
    logic [OW-1:0]    mk_ord;
    logic [TAG_W-1:0] mk_head, mk_tail;
    t_state           mk_ret;

    bpa_ram #(.DEPTH(PAGES), .WIDTH(TAG_W)) u_tag (
        .i_clk  (i_clk),
        .i_we   (tag_we),
        .i_waddr(tag_waddr),
        .i_wdata(tag_wdata),
        .i_raddr(tag_raddr),
        .o_rdata(w_tag_rd)
    );

    bpa_ram #(.DEPTH(PAGES), .WIDTH(LW)) u_link (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(link_raddr),
        .o_rdata(w_link_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            for (int k = 0; k <= MAX_ORDER; k++) r_head[k] <= LINK_NONE;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            for (int k = 0; k <= MAX_ORDER; k++) r_head[k] <= n_head[k];
        end
        r_ret     <= n_ret;
        r_end     <= n_end;
        r_s       <= n_s;
        r_cnt     <= n_cnt;
        r_mk_base <= n_mk_base;
        r_mk_i    <= n_mk_i;
        r_mk_n    <= n_mk_n;
        r_mk_head <= n_mk_head;
        r_mk_tail <= n_mk_tail;
        r_cur     <= n_cur;
        r_need    <= n_need;
        r_mo      <= n_mo;
        r_order   <= n_order;
        r_idx     <= n_idx;
        r_mi      <= n_mi;
        r_b       <= n_b;
        r_prev    <= n_prev;
        r_ucur    <= n_ucur;
        r_res     <= n_res;
    end

    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_ptr = r_ptr;   n_end = r_end;
        n_s = r_s;           n_cnt = r_cnt;     n_mk_base = r_mk_base;
        n_mk_i = r_mk_i;     n_mk_n = r_mk_n;   n_mk_head = r_mk_head;
        n_mk_tail = r_mk_tail; n_cur = r_cur;   n_need = r_need; n_mo = r_mo;
        n_order = r_order;   n_idx = r_idx;     n_mi = r_mi;     n_b = r_b;
        n_prev = r_prev;     n_ucur = r_ucur;   n_res = r_res;
        for (int k = 0; k <= MAX_ORDER; k++) n_head[k] = r_head[k];

        tag_we = 1'b0;  tag_waddr = '0;  tag_wdata = TAG_USED;  tag_raddr = '0;
        link_we = 1'b0; link_waddr = '0; link_wdata = LINK_NONE; link_raddr = '0;
        mk_go = 1'b0; mk_push = 1'b0; mk_base = '0; mk_ord = '0;
        mk_head = TAG_BUDDY; mk_tail = TAG_BUDDY; mk_ret = S_DONE;
        fin = 1'b0;
        o_res_valid = 1'b0;

        lim = (AW'(i_cfg.usable_pages) < PAGES_A) ? AW'(i_cfg.usable_pages) : PAGES_A;
        end_a = AW'(i_in.page_index) + AW'(i_in.req_pages);
        need  = f_need(AW'(i_in.req_pages));
        ord   = f_carve(r_s, r_cnt);
        half  = AW'(r_idx) + (AW'(1) << (r_cur - OW'(1)));
        b     = AW'(r_mi) ^ (AW'(1) << r_mo);
        addr  = r_mk_base + r_mk_i;

        // Smallest nonempty list at or above the needed order
        found = 1'b0;
        cur   = '0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if (OW'(k) >= need && r_head[k] < LW'(PAGES)) begin
                found = 1'b1;
                cur   = OW'(k);
            end
        end

        case (r_state)
            S_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = IW'(r_ptr);
                tag_wdata = TAG_USED;
                n_ptr     = r_ptr + AW'(1);
                if (r_ptr == PAGES_A - AW'(1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_in.action)
                        ACT_ADD: begin
                            if (i_in.req_pages == '0 || end_a > lim) begin
                                n_res.status = ST_BAD;
                            end else begin
                                n_res.block_index = i_in.page_index;
                                n_s       = AW'(i_in.page_index);
                                n_ptr     = AW'(i_in.page_index);
                                n_cnt     = AW'(i_in.req_pages);
                                n_end     = end_a;
                                tag_raddr = IW'(i_in.page_index);
                                n_state   = S_ADD_SCAN;
                            end
                        end
                        ACT_ALLOC: begin
                            if (!i_cfg.enable) begin
                                n_res.status = ST_DISABLED;
                            end else if (i_in.req_pages == '0 ||
                                         need > OW'(MAX_ORDER)) begin
                                n_res.status = ST_BAD;
                            end else if (!found) begin
                                n_res.status = ST_NOMEM;
                            end else begin
                                link_raddr = IW'(r_head[cur]);
                                n_idx      = IW'(r_head[cur]);
                                n_cur      = cur;
                                n_need     = need;
                                n_state    = S_ALLOC_POP;
                            end
                        end
                        ACT_FREE: begin
                            if (!i_cfg.enable) begin
                                n_res.status = ST_DISABLED;
                            end else if (AW'(i_in.page_index) >= lim) begin
                                n_res.status = ST_BAD;
                            end else begin
                                tag_raddr = IW'(i_in.page_index);
                                n_mi      = IW'(i_in.page_index);
                                n_state   = S_FREE_TAG;
                            end
                        end
                        default: n_res.status = ST_BAD;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                // Data for frame r_ptr arrives; stream the next read
                if (w_tag_rd != TAG_USED) begin
                    n_res        = '0;
                    n_res.status = ST_BAD;
                    n_state      = S_DONE;
                end else if (r_ptr + AW'(1) == r_end) begin
                    n_state = S_CARVE;
                end else begin
                    tag_raddr = IW'(r_ptr + AW'(1));
                    n_ptr     = r_ptr + AW'(1);
                end
            end
            S_CARVE: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    mk_go   = 1'b1;
                    mk_push = 1'b1;
                    mk_base = r_s;
                    mk_ord  = ord;
                    mk_head = TAG_W'(ord);
                    mk_tail = TAG_BUDDY;
                    mk_ret  = S_CARVE;
                    n_s     = r_s + (AW'(1) << ord);
                    n_cnt   = r_cnt - (AW'(1) << ord);
                end
            end
            S_ALLOC_POP: begin
                n_head[r_cur] = w_link_rd;
                n_state       = S_SPLIT;
            end
            S_SPLIT: begin
                if (r_cur > r_need) begin
                    mk_go   = 1'b1;
                    mk_push = 1'b1;
                    mk_base = half;
                    mk_ord  = r_cur - OW'(1);
                    mk_head = TAG_W'(r_cur - OW'(1));
                    mk_tail = TAG_BUDDY;
                    mk_ret  = S_SPLIT;
                    n_cur   = r_cur - OW'(1);
                end else begin
                    mk_go   = 1'b1;
                    mk_base = AW'(r_idx);
                    mk_ord  = r_need;
                    mk_head = TAG_ALLOC_BASE + TAG_W'(r_need);
                    mk_tail = TAG_ALLOC_TAIL;
                    mk_ret  = S_DONE;
                    n_res.status       = ST_OK;
                    n_res.block_index  = BIDX_W'(r_idx);
                    n_res.block_order  = ORD_W'(r_need);
                    n_res.final_order  = ORD_W'(r_need);
                end
            end
            S_FREE_TAG: begin
                if (w_tag_rd < TAG_ALLOC_BASE ||
                    w_tag_rd > TAG_ALLOC_BASE + TAG_W'(MAX_ORDER)) begin
                    n_res.status = ST_NOTHEAD;
                    n_state      = S_DONE;
                end else begin
                    n_mo    = OW'(w_tag_rd - TAG_ALLOC_BASE);
                    n_order = OW'(w_tag_rd - TAG_ALLOC_BASE);
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (r_mo < OW'(MAX_ORDER) && b < lim) begin
                    tag_raddr = IW'(b);
                    n_b       = IW'(b);
                    n_state   = S_MERGE_TAG;
                end else begin
                    fin = 1'b1;
                end
            end
            S_MERGE_TAG: begin
                if (w_tag_rd != TAG_W'(r_mo)) begin
                    fin = 1'b1;
                end else begin
                    n_prev  = LINK_NONE;
                    n_ucur  = r_head[r_mo];
                    n_state = S_UL_RD;
                end
            end
            S_UL_RD: begin
                if (r_ucur >= LW'(PAGES)) begin
                    fin = 1'b1;
                end else begin
                    link_raddr = IW'(r_ucur);
                    n_state    = S_UL_WT;
                end
            end
            S_UL_WT: begin
                if (IW'(r_ucur) == r_b) begin
                    // Unlink the buddy and climb one order
                    if (r_prev == LINK_NONE) begin
                        n_head[r_mo] = w_link_rd;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = IW'(r_prev);
                        link_wdata = w_link_rd;
                    end
                    n_mi    = (r_b < r_mi) ? r_b : r_mi;
                    n_mo    = r_mo + OW'(1);
                    n_state = S_MERGE;
                end else begin
                    n_prev  = r_ucur;
                    n_ucur  = w_link_rd;
                    n_state = S_UL_RD;
                end
            end
            S_MARK: begin
                if (addr < PAGES_A) begin
                    tag_we    = 1'b1;
                    tag_waddr = IW'(addr);
                    tag_wdata = (r_mk_i == '0) ? r_mk_head : r_mk_tail;
                end
                n_mk_i = r_mk_i + AW'(1);
                if (r_mk_i + AW'(1) == r_mk_n) n_state = r_ret;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            mk_go   = 1'b1;
            mk_push = 1'b1;
            mk_base = AW'(r_mi);
            mk_ord  = r_mo;
            mk_head = TAG_W'(r_mo);
            mk_tail = TAG_BUDDY;
            mk_ret  = S_DONE;
            n_res.status       = ST_OK;
            n_res.block_index  = BIDX_W'(r_mi);
            n_res.block_order  = ORD_W'(r_order);
            n_res.final_order  = ORD_W'(r_mo);
        end

        if (mk_go) begin
            n_mk_base = mk_base;
            n_mk_i    = '0;
            n_mk_n    = AW'(1) << mk_ord;
            n_mk_head = mk_head;
            n_mk_tail = mk_tail;
            n_ret     = mk_ret;
            n_state   = S_MARK;
            if (mk_push) begin
                link_we        = 1'b1;
                link_waddr     = IW'(mk_base);
                link_wdata     = r_head[mk_ord];
                n_head[mk_ord] = LW'(mk_base);
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

// File: rtl/buddy_page_allocator.sv
// Buddy page allocator over PAGES frames with per-order free lists.
// Work is set by one frame tag written or checked per cycle (add scan, block marking)
// and by a link read per list node on unlink.
// Throughput: one item at a time; a finished result waits in the output register.
// Reset: synchronous, active low; a clearing pass then marks every frame used, during which
// no item is taken. Config writes are taken at any time.
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int PAGES     = PAGES_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [USABLE_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic r_out_valid;
    t_out r_out;
    logic seq_busy, res_valid, res_ready;
    t_out seq_res;

    // Configuration registers; always ready to take a transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable       <= 1'b0;
            r_cfg.usable_pages <= USABLE_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLE: r_cfg.enable       <= i_cfg_data[0];
                CFG_USABLE: r_cfg.usable_pages <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bpa_seq #(.PAGES(PAGES), .MAX_ORDER(MAX_ORDER)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_valid),
        .o_busy     (seq_busy),
        .i_in       (i_data),
        .i_res_ready(res_ready),
        .o_res_valid(res_valid),
        .o_res      (seq_res)
    );

    // Stall the input while the sequencer works on an item or clears memory
    assign o_stall = seq_busy;

    // Output register: load when empty or when the held result transfers
    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
